### design/wsmh_pkg.sv
// ----------------------------------------------------------------------------
// wsmh_pkg
// Shared constants and types for the word splitter with per-word hashing.
// ----------------------------------------------------------------------------
package wsmh_pkg;

    localparam int MAX_WORD_LEN = 64;
    localparam int CNT_W        = $clog2(MAX_WORD_LEN + 1);
    localparam int WORD_ENTRIES = (MAX_WORD_LEN + 3) / 4;
    localparam int CHUNK_W      = (WORD_ENTRIES > 1) ? $clog2(WORD_ENTRIES) : 1;
    localparam int LEN_OUT_W    = 7;

    localparam logic [31:0] MURMUR_MUL  = 32'hc6a4a793;
    localparam logic [31:0] SEED_RESET  = 32'd42;
    localparam logic [7:0]  SPACE_BYTE  = 8'd32;
    localparam logic [7:0]  END_BYTE    = 8'd0;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] len;
        logic             ovf;
        logic [31:0]      seed;
    } t_start;

    typedef struct packed {
        logic [31:0]          hash;
        logic [LEN_OUT_W-1:0] length;
        logic                 too_long;
    } t_result;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } t_eng_stat;

endpackage

### design/wsmh_hash_engine.sv
// ----------------------------------------------------------------------------
// wsmh_hash_engine
// Multi-cycle MurmurHash1 engine that walks the word buffer one 32-bit
// chunk at a time and holds its result until the output stage takes it.
// ----------------------------------------------------------------------------
module wsmh_hash_engine
    import wsmh_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_start             i_start,
    output logic [CHUNK_W-1:0] o_rd_addr,
    input  logic [31:0]        i_rd_data,
    output t_eng_stat          o_stat,
    output t_result            o_res,
    input  logic               i_res_ready
);

    typedef enum logic [9:0] {
        E_IDLE  = 10'b0000000001,
        E_SEED  = 10'b0000000010,
        E_LOAD  = 10'b0000000100,
        E_SHIFT = 10'b0000001000,
        E_FIN1  = 10'b0000010000,
        E_FIN2  = 10'b0000100000,
        E_FIN3  = 10'b0001000000,
        E_FIN4  = 10'b0010000000,
        E_DONE  = 10'b0100000000,
        E_SPARE = 10'b1000000000
    } t_eng_state;

    t_eng_state         r_state, n_state;
    logic [31:0]        r_h, n_h;
    logic [CNT_W-1:0]   r_rest, n_rest;
    logic [CNT_W-1:0]   r_len, n_len;
    logic [CHUNK_W-1:0] r_chunk, n_chunk;
    logic               r_ovf, n_ovf;
    logic [31:0]        chunk_k;
    logic [31:0]        chunk_sum;

    always_comb begin
        priority if (r_rest >= CNT_W'(4)) begin
            chunk_k = i_rd_data;
        end else if (r_rest == CNT_W'(3)) begin
            chunk_k = {8'd0, i_rd_data[23:0]};
        end else if (r_rest == CNT_W'(2)) begin
            chunk_k = {16'd0, i_rd_data[15:0]};
        end else begin
            chunk_k = {24'd0, i_rd_data[7:0]};
        end
    end

    assign chunk_sum = r_h + chunk_k;

    always_comb begin
        n_state = r_state;
        n_h     = r_h;
        n_rest  = r_rest;
        n_len   = r_len;
        n_chunk = r_chunk;
        n_ovf   = r_ovf;
        unique case (r_state)
            E_IDLE: begin
                if (i_start.start) begin
                    n_len   = i_start.len;
                    n_rest  = i_start.len;
                    n_chunk = '0;
                    n_ovf   = i_start.ovf;
                    if (i_start.ovf) begin
                        n_h     = '0;
                        n_state = E_DONE;
                    end else begin
                        n_h     = i_start.seed;
                        n_state = E_SEED;
                    end
                end
            end
            E_SEED: begin
                n_h     = r_h ^ (32'(r_len) * MURMUR_MUL);
                n_state = E_LOAD;
            end
            E_LOAD: begin
                if (r_rest == '0) begin
                    n_state = E_FIN1;
                end else begin
                    n_h     = chunk_sum * MURMUR_MUL;
                    n_rest  = (r_rest >= CNT_W'(4)) ? r_rest - CNT_W'(4) : '0;
                    n_chunk = r_chunk + CHUNK_W'(1);
                    n_state = E_SHIFT;
                end
            end
            E_SHIFT: begin
                n_h     = r_h ^ (r_h >> 16);
                n_state = E_LOAD;
            end
            E_FIN1: begin
                n_h     = r_h * MURMUR_MUL;
                n_state = E_FIN2;
            end
            E_FIN2: begin
                n_h     = r_h ^ (r_h >> 10);
                n_state = E_FIN3;
            end
            E_FIN3: begin
                n_h     = r_h * MURMUR_MUL;
                n_state = E_FIN4;
            end
            E_FIN4: begin
                n_h     = r_h ^ (r_h >> 17);
                n_state = E_DONE;
            end
            E_DONE: begin
                if (i_res_ready) begin
                    n_state = E_IDLE;
                end
            end
            default: begin
                n_state = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h     <= n_h;
        r_rest  <= n_rest;
        r_len   <= n_len;
        r_chunk <= n_chunk;
        r_ovf   <= n_ovf;
    end

    assign o_rd_addr        = r_chunk;
    assign o_stat.idle      = (r_state == E_IDLE);
    assign o_stat.res_valid = (r_state == E_DONE);
    assign o_res.hash       = r_h;
    assign o_res.length     = LEN_OUT_W'(r_len);
    assign o_res.too_long   = r_ovf;

    a_ovf_hash_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == E_DONE && r_ovf) |-> (r_h == '0))
        else $error("overflowed word finished with a nonzero hash");

    a_start_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start.start |-> (r_state == E_IDLE))
        else $error("hash start while engine busy");

endmodule

### design/word_split_murmur1_hasher_core.sv
// ----------------------------------------------------------------------------
// word_split_murmur1_hasher_core
// Splits a byte stream into space-separated words, buffers each word and
// emits its MurmurHash1 value with its length when the word ends.
//
//   Channel   Direction  Handshake                   Payload
//   input     in         i_in_valid / o_in_ready     i_text_byte, i_final_byte
//   output    out        o_out_valid / i_out_ready   o_word_hash, o_word_length,
//                                                    o_too_long
//   config    in         i_hash_seed_wr_en           i_hash_seed_wr_data
//
// A byte that ends no word leaves input open. A byte that ends a word
// blocks input while the hash engine mixes in the length, reads the buffer
// chunk by chunk and runs its finaliser. An overflowed word skips hashing
// but blocks input until its result is passed on. Reset is synchronous and
// needs no clearing pass. The output register lets input continue while a
// result waits; the engine holds its next result if that register is full.
// ----------------------------------------------------------------------------
module word_split_murmur1_hasher_core
    import wsmh_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_hash_seed_wr_en,
    input  logic [31:0]          i_hash_seed_wr_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_text_byte,
    input  logic                 i_final_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [31:0]          o_word_hash,
    output logic [LEN_OUT_W-1:0] o_word_length,
    output logic                 o_too_long
);

    logic [31:0]        r_seed;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_ovf, n_ovf;
    logic               r_run, n_run;
    logic               r_end, n_end;
    logic [31:0]        r_word_store [WORD_ENTRIES];
    logic [31:0]        r_rd_data;
    logic               r_out_valid;
    t_result            r_out;

    logic               accept;
    logic               emit;
    logic               wr_en;
    logic [CNT_W-1:0]   cnt_after;
    logic               ovf_after;
    logic               run_after;
    logic               end_after;
    logic [CHUNK_W-1:0] rd_addr;
    logic               out_take;
    t_start             start;
    t_eng_stat          eng_stat;
    t_result            eng_res;

    assign o_in_ready = eng_stat.idle;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        cnt_after = r_count;
        ovf_after = r_ovf;
        run_after = r_run;
        end_after = r_end;
        emit      = 1'b0;
        wr_en     = 1'b0;
        if (!r_end) begin
            if (i_text_byte == SPACE_BYTE) begin
                emit      = (r_count != '0);
                run_after = 1'b1;
            end else if (i_text_byte == END_BYTE) begin
                emit      = (r_count != '0) || r_run;
                run_after = 1'b0;
                end_after = 1'b1;
            end else begin
                run_after = 1'b0;
                if (r_count < CNT_W'(MAX_WORD_LEN)) begin
                    wr_en     = 1'b1;
                    cnt_after = r_count + CNT_W'(1);
                end else begin
                    ovf_after = 1'b1;
                end
            end
            if (i_final_byte && !end_after && !emit
                    && ((cnt_after != '0) || run_after)) begin
                emit = 1'b1;
            end
        end
    end

    always_comb begin
        n_count = r_count;
        n_ovf   = r_ovf;
        n_run   = r_run;
        n_end   = r_end;
        if (accept) begin
            n_count = emit ? '0 : cnt_after;
            n_ovf   = emit ? 1'b0 : ovf_after;
            n_run   = run_after;
            n_end   = end_after;
            if (i_final_byte) begin
                n_count = '0;
                n_ovf   = 1'b0;
                n_run   = 1'b0;
                n_end   = 1'b0;
            end
        end
    end

    assign start.start = accept && emit;
    assign start.len   = cnt_after;
    assign start.ovf   = ovf_after;
    assign start.seed  = r_seed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed  <= SEED_RESET;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_run   <= 1'b0;
            r_end   <= 1'b0;
        end else begin
            if (i_hash_seed_wr_en) begin
                r_seed <= i_hash_seed_wr_data;
            end
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_run   <= n_run;
            r_end   <= n_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && wr_en) begin
            r_word_store[CHUNK_W'(r_count >> 2)][r_count[1:0]*8 +: 8] <= i_text_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_word_store[rd_addr];
    end

    wsmh_hash_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (r_rd_data),
        .o_stat      (eng_stat),
        .o_res       (eng_res),
        .i_res_ready (out_take)
    );

    assign out_take = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_take) begin
            r_out_valid <= eng_stat.res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take && eng_stat.res_valid) begin
            r_out <= eng_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_word_hash   = r_out.hash;
    assign o_word_length = r_out.length;
    assign o_too_long    = r_out.too_long;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_WORD_LEN))
        else $error("word byte count beyond buffer size");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_count == CNT_W'(MAX_WORD_LEN)))
        else $error("overflow flag set with buffer not full");

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_final_byte) |=> (r_count == '0 && !r_ovf && !r_run && !r_end))
        else $error("run state not cleared after final byte");

    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !eng_stat.idle |-> !accept)
        else $error("byte transaction accepted while hashing");

endmodule

### tb/tb_word_split_murmur1_hasher_core.sv
// ----------------------------------------------------------------------------
// tb_word_split_murmur1_hasher_core
// Feeds byte streams through the word splitter and checks every word hash.
// A short table of hand-picked bytes comes first. It covers separators, end
// bytes, ignored bytes, empty words, overflowing words and final-byte
// handling. Random partitions follow under several seeds and idle patterns.
// Every output transaction is compared field by field against a local
// MurmurHash1 predictor with its own word buffer, or a typed table result.
// ----------------------------------------------------------------------------
module tb_word_split_murmur1_hasher_core;
    timeunit 1ns;
    timeprecision 1ps;
    import wsmh_pkg::*;

    typedef enum int {CHK_PREDICT, CHK_TYPED, CHK_NONE} t_check;

    typedef struct {
        logic [7:0] text;
        logic       fin;
        int         reps;
        t_check     check;
        t_result    typed;
    } t_row;

    localparam t_result NO_WORD  = '0;
    localparam t_result OVF_WORD = '{hash: 32'h0, length: LEN_OUT_W'(MAX_WORD_LEN),
                                     too_long: 1'b1};

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_hash_seed_wr_en = 1'b0;
    logic [31:0]          i_hash_seed_wr_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [7:0]           i_text_byte = '0;
    logic                 i_final_byte = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [31:0]          o_word_hash;
    logic [LEN_OUT_W-1:0] o_word_length;
    logic                 o_too_long;

    logic [7:0]  word_buf [MAX_WORD_LEN];
    int          word_len = 0;
    bit          word_ovf = 1'b0;
    bit          space_run = 1'b0;
    bit          data_done = 1'b0;
    logic [31:0] cur_seed = SEED_RESET;

    t_result pending_words [$];
    int      mismatches = 0;
    int      bytes_fed = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;

    t_row dir_rows [25] = '{
        '{8'h00, 1'b0,  1, CHK_NONE,    NO_WORD},
        '{8'h41, 1'b0,  1, CHK_NONE,    NO_WORD},
        '{8'hff, 1'b1,  1, CHK_NONE,    NO_WORD},
        '{8'h01, 1'b0,  1, CHK_PREDICT, NO_WORD},
        '{8'hff, 1'b0,  1, CHK_PREDICT, NO_WORD},
        '{8'h20, 1'b0,  1, CHK_PREDICT, NO_WORD},
        '{8'h20, 1'b0,  1, CHK_PREDICT, NO_WORD},
        '{8'h00, 1'b0,  1, CHK_PREDICT, NO_WORD},
        '{8'h7f, 1'b1,  1, CHK_NONE,    NO_WORD},
        '{8'h61, 1'b0, 65, CHK_PREDICT, NO_WORD},
        '{8'h20, 1'b0,  1, CHK_TYPED,   OVF_WORD},
        '{8'h62, 1'b0, 64, CHK_PREDICT, NO_WORD},
        '{8'h20, 1'b0,  1, CHK_PREDICT, NO_WORD},
        '{8'h63, 1'b0,  3, CHK_PREDICT, NO_WORD},
        '{8'h00, 1'b0,  1, CHK_PREDICT, NO_WORD},
        '{8'h00, 1'b1,  1, CHK_NONE,    NO_WORD},
        '{8'h78, 1'b1,  1, CHK_PREDICT, NO_WORD},
        '{8'h79, 1'b0,  5, CHK_PREDICT, NO_WORD},
        '{8'h20, 1'b1,  1, CHK_PREDICT, NO_WORD},
        '{8'h20, 1'b1,  1, CHK_PREDICT, NO_WORD},
        '{8'h7a, 1'b0, 70, CHK_PREDICT, NO_WORD},
        '{8'h00, 1'b0,  1, CHK_TYPED,   OVF_WORD},
        '{8'h20, 1'b1,  1, CHK_NONE,    NO_WORD},
        '{8'h71, 1'b0, 66, CHK_PREDICT, NO_WORD},
        '{8'h71, 1'b1,  1, CHK_TYPED,   OVF_WORD}
    };

    word_split_murmur1_hasher_core u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_hash_seed_wr_en   (i_hash_seed_wr_en),
        .i_hash_seed_wr_data (i_hash_seed_wr_data),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_text_byte         (i_text_byte),
        .i_final_byte        (i_final_byte),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_word_hash         (o_word_hash),
        .o_word_length       (o_word_length),
        .o_too_long          (o_too_long)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [31:0] word_digest(input logic [31:0] seed);
        logic [31:0] h;
        int          pos;
        int          rest;
        h = seed ^ (32'(word_len) * MURMUR_MUL);
        pos = 0;
        while (word_len - pos >= 4) begin
            h = h + {word_buf[pos+3], word_buf[pos+2], word_buf[pos+1], word_buf[pos]};
            h = h * MURMUR_MUL;
            h = h ^ (h >> 16);
            pos += 4;
        end
        rest = word_len - pos;
        if (rest > 0) begin
            if (rest >= 3) h = h + {8'h00, word_buf[pos+2], 16'h0000};
            if (rest >= 2) h = h + {16'h0000, word_buf[pos+1], 8'h00};
            h = h + {24'h000000, word_buf[pos]};
            h = h * MURMUR_MUL;
            h = h ^ (h >> 16);
        end
        h = h * MURMUR_MUL;
        h = h ^ (h >> 10);
        h = h * MURMUR_MUL;
        h = h ^ (h >> 17);
        return h;
    endfunction

    function automatic t_result finish_word();
        t_result res;
        if (word_ovf) begin
            res = OVF_WORD;
        end else begin
            res.hash     = word_digest(cur_seed);
            res.length   = LEN_OUT_W'(word_len);
            res.too_long = 1'b0;
        end
        word_len = 0;
        word_ovf = 1'b0;
        return res;
    endfunction

    function automatic bit take_byte(input logic [7:0] b, input logic fin,
                                     output t_result res);
        bit got;
        got = 1'b0;
        res = NO_WORD;
        if (!data_done) begin
            if (b == SPACE_BYTE) begin
                if (word_len > 0) begin
                    res = finish_word();
                    got = 1'b1;
                end
                space_run = 1'b1;
            end else if (b == END_BYTE) begin
                if (word_len > 0 || space_run) begin
                    res = finish_word();
                    got = 1'b1;
                end
                space_run = 1'b0;
                data_done = 1'b1;
            end else begin
                space_run = 1'b0;
                if (word_len < MAX_WORD_LEN) begin
                    word_buf[word_len] = b;
                    word_len++;
                end else begin
                    word_ovf = 1'b1;
                end
            end
            if (fin && !data_done && !got && (word_len > 0 || space_run)) begin
                res = finish_word();
                got = 1'b1;
            end
        end
        if (fin) begin
            word_len  = 0;
            word_ovf  = 1'b0;
            space_run = 1'b0;
            data_done = 1'b0;
        end
        return got;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task automatic put_byte(input logic [7:0] b, input logic fin, input t_check check,
                            input t_result typed);
        int      gap;
        t_result res;
        bit      got;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_text_byte  <= b;
        i_final_byte <= fin;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (!data_done) bytes_fed++;
        got = take_byte(b, fin, res);
        if (check == CHK_TYPED) begin
            pending_words.push_back(typed);
        end else if (check == CHK_PREDICT && got) begin
            pending_words.push_back(res);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic load_seed(input logic [31:0] seed);
        i_hash_seed_wr_en   <= 1'b1;
        i_hash_seed_wr_data <= seed;
        @(posedge i_clk);
        i_hash_seed_wr_en <= 1'b0;
        cur_seed = seed;
    endtask

    task automatic send_partition();
        int         words;
        int         w;
        int         len;
        int         i;
        int         ending;
        int         pad;
        int         pick;
        bit         trail;
        logic [7:0] b;
        if ($urandom_range(9) == 0) begin
            len = $urandom_range(1, 12);
            for (i = 0; i < len; i++) begin
                case ($urandom_range(9))
                    0, 1, 2: b = SPACE_BYTE;
                    3:       b = END_BYTE;
                    default: b = 8'($urandom_range(255));
                endcase
                put_byte(b, (i == len - 1) || ($urandom_range(19) == 0), CHK_PREDICT, NO_WORD);
            end
        end else begin
            words  = $urandom_range(1, 6);
            ending = $urandom_range(3);
            trail  = (ending == 1) || (ending >= 2 && $urandom_range(3) == 0);
            for (w = 0; w < words; w++) begin
                pick = $urandom_range(99);
                if (pick < 80) len = $urandom_range(1, 12);
                else if (pick < 92) len = $urandom_range(13, 63);
                else if (pick < 97) len = $urandom_range(64, 66);
                else len = $urandom_range(67, 80);
                for (i = 0; i < len; i++) begin
                    do b = 8'($urandom_range(1, 255)); while (b == SPACE_BYTE);
                    put_byte(b, (w == words - 1) && (i == len - 1) && (ending == 0),
                             CHK_PREDICT, NO_WORD);
                end
                if (w < words - 1 || (trail && ending != 0)) begin
                    pad = $urandom_range(1, 3);
                    for (i = 0; i < pad; i++) begin
                        put_byte(SPACE_BYTE, (w == words - 1) && (i == pad - 1) && (ending == 1),
                                 CHK_PREDICT, NO_WORD);
                    end
                end
            end
            if (ending >= 2) begin
                pad = (ending == 3) ? 0 : $urandom_range(1, 4);
                put_byte(END_BYTE, pad == 0, CHK_PREDICT, NO_WORD);
                for (i = 0; i < pad; i++) begin
                    put_byte(8'($urandom_range(255)), i == pad - 1, CHK_PREDICT, NO_WORD);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_words.size() == 0) begin
                note_mismatch($sformatf("unexpected word result, hash %h length %0d",
                                        o_word_hash, o_word_length));
            end else begin
                want = pending_words.pop_front();
                if (o_word_hash !== want.hash) begin
                    note_mismatch($sformatf("word_hash %h, expected %h", o_word_hash, want.hash));
                end
                if (o_word_length !== want.length) begin
                    note_mismatch($sformatf("word_length %0d, expected %0d",
                                            o_word_length, want.length));
                end
                if (o_too_long !== want.too_long) begin
                    note_mismatch($sformatf("too_long %b, expected %b",
                                            o_too_long, want.too_long));
                end
            end
        end
    end

    initial begin
        #10ms;
        $display("word_split_murmur1_hasher_core verification failed");
        $finish;
    end

    initial begin : stimulus
        int          row;
        int          k;
        int          phase;
        int          phase_start;
        bit          paused;
        logic [31:0] seed;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (row = 0; row < 25; row++) begin
            for (k = 0; k < dir_rows[row].reps; k++) begin
                if (k == dir_rows[row].reps - 1) begin
                    put_byte(dir_rows[row].text, dir_rows[row].fin, dir_rows[row].check,
                             dir_rows[row].typed);
                end else begin
                    put_byte(dir_rows[row].text, 1'b0, CHK_PREDICT, NO_WORD);
                end
            end
        end
        drain();

        for (phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 0;  recv_stall_pct = 0;  seed = 32'h0000_0000;
                end
                1: begin
                    send_idle_pct = 66; recv_stall_pct = 0;  seed = 32'hffff_ffff;
                end
                2: begin
                    send_idle_pct = 0;  recv_stall_pct = 66; seed = $urandom;
                end
                3: begin
                    send_idle_pct = 32; recv_stall_pct = 32; seed = $urandom;
                end
                default: begin
                    send_idle_pct = 0;  recv_stall_pct = 0;  seed = SEED_RESET;
                end
            endcase
            load_seed(seed);
            phase_start = bytes_fed;
            paused = 1'b0;
            while (bytes_fed - phase_start < 240) begin
                send_partition();
                if (!paused && bytes_fed - phase_start >= 120) begin
                    drain();
                    paused = 1'b1;
                end
            end
            drain();
        end

        if (mismatches == 0) begin
            $display("word_split_murmur1_hasher_core verification clean");
        end else begin
            $display("word_split_murmur1_hasher_core verification failed");
        end
        $finish;
    end

endmodule
